// File: rtl/stopping_distance_velocity_limit_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stopping distance velocity limit core
// Shared property forms; they expect clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef STOPPING_DISTANCE_VELOCITY_LIMIT_CORE_ASSERT_SVH
`define STOPPING_DISTANCE_VELOCITY_LIMIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SDVL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SDVL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sdvl_pkg.sv
// ----------------------------------------------------------------------------
// sdvl_pkg
// Widths, constants and side-band types of the stopping distance core.
// ----------------------------------------------------------------------------
package sdvl_pkg;

	localparam int SPD_W      = 13;
	localparam int RATE_W     = 14;
	localparam int INTV_W     = 10;
	localparam int MINC_W     = 16;
	localparam int GUARD_W    = 13;
	localparam int ACC_W      = 14;
	localparam int SCALE_W    = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL  = 3'd0,
		REG_MIN_CLEAR = 3'd1,
		REG_GUARD     = 3'd2,
		REG_ACCEL     = 3'd3,
		REG_SCALE     = 3'd4
	} cfg_reg_t;

	// interval * |rate|, and the floored quotient by 1000
	localparam int CYC_P_W = INTV_W + RATE_W;
	localparam int CYC_W   = 14;

	// floor(p / 1000) = (p * ceil(2^33 / 1000)) >> 33, exact for p below 2^24
	localparam int              RECIP_W     = 24;
	localparam int              RECIP_SHIFT = 33;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;

	typedef logic signed [SPD_W-1:0] speed_t;

	typedef struct packed {
		logic   rot;
		logic   neg;
		logic   pass;
		speed_t wlo;
		speed_t whi;
	} sdvl_side_t;

endpackage

// File: rtl/sdvl_front.sv
// ----------------------------------------------------------------------------
// sdvl_front
// Four stages: cycle margin, distance or angle, threshold test, brake product.
// ----------------------------------------------------------------------------
module sdvl_front #(
	parameter int DIST_BITS = 16,
	parameter int RAD_W     = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [DIST_BITS-1:0]              clearance,
	input  sdvl_pkg::speed_t                  traj_speed,
	input  sdvl_pkg::speed_t                  window_low,
	input  sdvl_pkg::speed_t                  window_high,
	input  sdvl_pkg::speed_t                  robot_speed,
	input  logic signed [sdvl_pkg::RATE_W-1:0] robot_turn_rate,
	input  logic                              emergency_active,
	input  logic [sdvl_pkg::INTV_W-1:0]       interval,
	input  logic [sdvl_pkg::MINC_W-1:0]       min_clear,
	input  logic [sdvl_pkg::GUARD_W-1:0]      guard,
	input  logic [sdvl_pkg::ACC_W-1:0]        accel,
	input  logic [sdvl_pkg::SCALE_W-1:0]      scale,
	output logic                              out_valid,
	output logic [RAD_W-1:0]                  rad,
	output sdvl_pkg::sdvl_side_t              out_side
);
	import sdvl_pkg::*;

	localparam int ANG_P_W = DIST_BITS + SCALE_W;
	localparam int BASE_W  = DIST_BITS + 4;
	localparam int SUB_W   = (BASE_W > CYC_W) ? BASE_W : CYC_W;
	localparam int CMP_W   = (BASE_W > MINC_W) ? BASE_W : MINC_W;
	localparam int QP_W    = CYC_P_W + RECIP_W;
	localparam int BRK_W   = DIST_BITS + ACC_W;

	// stage 1: pick the rate, take its magnitude, start both products
	logic                     rot;
	logic signed [RATE_W-1:0] rate;
	logic [RATE_W-1:0]        rate_mag;

	always_comb begin
		rot      = (traj_speed == '0);
		rate     = rot ? robot_turn_rate : {robot_speed[SPD_W-1], robot_speed};
		rate_mag = rate[RATE_W-1] ? RATE_W'(-rate) : RATE_W'(rate);
	end

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [CYC_P_W-1:0]   cyc_prod_s1;
	logic [ANG_P_W-1:0]   ang_prod_s1;
	logic [DIST_BITS-1:0] clear_s1;
	logic                 emerg_s1, emerg_s2;
	sdvl_side_t           side_s1, side_s2, side_s3, side_s4;
	logic [CYC_W-1:0]     cyc_s2;
	logic [BASE_W-1:0]    base_s2;
	logic [DIST_BITS-1:0] dist_s3;
	logic [RAD_W-1:0]     rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		cyc_prod_s1  <= CYC_P_W'(interval) * CYC_P_W'(rate_mag);
		ang_prod_s1  <= ANG_P_W'(clearance) * ANG_P_W'(scale);
		clear_s1     <= clearance;
		emerg_s1     <= emergency_active;
		side_s1.rot  <= rot;
		side_s1.neg  <= traj_speed[SPD_W-1];
		side_s1.pass <= 1'b0;
		side_s1.wlo  <= window_low;
		side_s1.whi  <= window_high;
	end

	// stage 2: divide the margin by 1000, select mm or mrad
	logic [QP_W-1:0] recip_prod;

	assign recip_prod = QP_W'(cyc_prod_s1) * QP_W'(RECIP_1000);

	always_ff @(posedge clk) begin
		cyc_s2   <= recip_prod[RECIP_SHIFT +: CYC_W];
		base_s2  <= side_s1.rot ? ang_prod_s1[ANG_P_W-1 -: BASE_W] : BASE_W'(clear_s1);
		emerg_s2 <= emerg_s1;
		side_s2  <= side_s1;
	end

	// stage 3: subtract the margin, clamp, halve in an emergency, test the threshold
	logic [SUB_W-1:0] base_x, cyc_x, span;
	logic [CMP_W-1:0] thr;
	logic             pass;

	always_comb begin
		base_x = SUB_W'(base_s2);
		cyc_x  = SUB_W'(cyc_s2);
		span   = (base_x > cyc_x) ? (base_x - cyc_x) : '0;
		if (emerg_s2) begin
			span = span >> 1;
		end
		thr  = side_s2.rot ? CMP_W'(guard) : CMP_W'(min_clear);
		pass = CMP_W'(span) > thr;
	end

	always_ff @(posedge clk) begin
		dist_s3      <= span[DIST_BITS-1:0];
		side_s3.rot  <= side_s2.rot;
		side_s3.neg  <= side_s2.neg;
		side_s3.pass <= pass;
		side_s3.wlo  <= side_s2.wlo;
		side_s3.whi  <= side_s2.whi;
	end

	// stage 4: radicand 2 * d * a
	logic [BRK_W-1:0] brake_prod;

	assign brake_prod = BRK_W'(dist_s3) * BRK_W'(accel);

	always_ff @(posedge clk) begin
		rad_s4  <= RAD_W'({brake_prod, 1'b0});
		side_s4 <= side_s3;
	end

	assign out_valid = valid_s4;
	assign rad       = rad_s4;
	assign out_side  = side_s4;

endmodule

// File: rtl/sdvl_isqrt.sv
// ----------------------------------------------------------------------------
// sdvl_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sdvl_isqrt #(
	parameter int RAD_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  sdvl_pkg::sdvl_side_t in_side,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output sdvl_pkg::sdvl_side_t out_side
);
	import sdvl_pkg::*;

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 1;

	// bring down two radicand bits, try (root << 2) | 1
	function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(
		input logic [REM_W-1:0]  rem,
		input logic [ROOT_W-1:0] rt,
		input logic [1:0]        pair
	);
		logic [REM_W+1:0] sh;
		logic [REM_W+1:0] trial;
		sh    = {rem, pair};
		trial = {1'b0, rt, 2'b01};
		if (sh >= trial) begin
			return {REM_W'(sh - trial), rt[ROOT_W-2:0], 1'b1};
		end
		return {REM_W'(sh), rt[ROOT_W-2:0], 1'b0};
	endfunction

	logic [REM_W-1:0]  rem_s  [ROOT_W-1];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  x_s    [ROOT_W-1];
	sdvl_side_t        side_s [ROOT_W];
	logic [ROOT_W-1:0] valid_s;

	logic [REM_W-1:0]  rem_nx  [ROOT_W];
	logic [ROOT_W-1:0] root_nx [ROOT_W];

	always_comb begin
		{rem_nx[0], root_nx[0]} = sqrt_step(REM_W'(0), ROOT_W'(0), rad[RAD_W-1 -: 2]);
		for (int i = 1; i < ROOT_W; i++) begin
			{rem_nx[i], root_nx[i]} = sqrt_step(rem_s[i-1], root_s[i-1],
				x_s[i-1][RAD_W-1 -: 2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[ROOT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= rad << 2;
		side_s[0] <= in_side;
		for (int i = 0; i < ROOT_W; i++) begin
			root_s[i] <= root_nx[i];
		end
		for (int i = 0; i < ROOT_W - 1; i++) begin
			rem_s[i] <= rem_nx[i];
		end
		for (int i = 1; i < ROOT_W - 1; i++) begin
			x_s[i] <= x_s[i-1] << 2;
		end
		for (int i = 1; i < ROOT_W; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

// File: rtl/stopping_distance_velocity_limit_core.sv
// ----------------------------------------------------------------------------
// stopping_distance_velocity_limit_core
// Admissibility test and braking speed cap for one candidate trajectory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is high only in reset and up to the first edge after it;
//   from then on a new trajectory may be issued in every cycle.
//   Result channel: done is high for exactly one cycle with admissible,
//   new_low and new_high; the receiver cannot stall, so results are never
//   held and the pipeline simply advances every cycle.
//   Pipeline: four front stages (margin product, division by 1000,
//   threshold test, brake product), one square root stage per root bit,
//   and the output register that drives done. Throughput is one per cycle.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at a
//   rising edge; write only while no transaction is in flight.
//   Reset clears the valid pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`include "stopping_distance_velocity_limit_core_assert.svh"

module stopping_distance_velocity_limit_core #(
	parameter int DIST_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdvl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sdvl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [DIST_BITS-1:0]                 clearance,
	input  logic signed [sdvl_pkg::SPD_W-1:0]    traj_speed,
	input  logic signed [sdvl_pkg::SPD_W-1:0]    window_low,
	input  logic signed [sdvl_pkg::SPD_W-1:0]    window_high,
	input  logic signed [sdvl_pkg::SPD_W-1:0]    robot_speed,
	input  logic signed [sdvl_pkg::RATE_W-1:0]   robot_turn_rate,
	input  logic                                 emergency_active,
	output logic                                 done,
	output logic                                 admissible,
	output logic signed [sdvl_pkg::SPD_W-1:0]    new_low,
	output logic signed [sdvl_pkg::SPD_W-1:0]    new_high
);
	import sdvl_pkg::*;

	// radicand 2*d*a needs DIST_BITS + 15 bits, rounded up to an even width
	localparam int RAD_W  = 2 * ((DIST_BITS + 16) / 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int VMAX_W = ROOT_W - 1;
	localparam int CMPV_W = ((VMAX_W > SPD_W) ? VMAX_W : SPD_W) + 2;
	// edges from the accepting edge to the edge that takes the result
	localparam int LAT    = ROOT_W + 5;

	// ------------------------------------------------------------------
	// Configuration registers; indexes past the list are dropped.
	// ------------------------------------------------------------------
	logic [INTV_W-1:0]  interval_q;
	logic [MINC_W-1:0]  min_clear_q;
	logic [GUARD_W-1:0] guard_q;
	logic [ACC_W-1:0]   accel_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTV_W'(250);
			min_clear_q <= MINC_W'(100);
			guard_q     <= GUARD_W'(87);
			accel_q     <= ACC_W'(500);
			scale_q     <= SCALE_W'(82348);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERVAL:  interval_q  <= cfg_wdata[INTV_W-1:0];
				REG_MIN_CLEAR: min_clear_q <= cfg_wdata[MINC_W-1:0];
				REG_GUARD:     guard_q     <= cfg_wdata[GUARD_W-1:0];
				REG_ACCEL:     accel_q     <= cfg_wdata[ACC_W-1:0];
				REG_SCALE:     scale_q     <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Command handshake: hold busy through reset and up to the first edge after.
	// ------------------------------------------------------------------
	logic ready_q;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = ~ready_q;
	assign accept = start & ~busy;

	// ------------------------------------------------------------------
	// Front stages: margin, clearance or angle, threshold, radicand.
	// ------------------------------------------------------------------
	logic             fr_valid;
	logic [RAD_W-1:0] fr_rad;
	sdvl_side_t       fr_side;

	sdvl_front #(
		.DIST_BITS (DIST_BITS),
		.RAD_W     (RAD_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (accept),
		.clearance        (clearance),
		.traj_speed       (traj_speed),
		.window_low       (window_low),
		.window_high      (window_high),
		.robot_speed      (robot_speed),
		.robot_turn_rate  (robot_turn_rate),
		.emergency_active (emergency_active),
		.interval         (interval_q),
		.min_clear        (min_clear_q),
		.guard            (guard_q),
		.accel            (accel_q),
		.scale            (scale_q),
		.out_valid        (fr_valid),
		.rad              (fr_rad),
		.out_side         (fr_side)
	);

	// ------------------------------------------------------------------
	// Square root of the radicand, one bit per stage.
	// ------------------------------------------------------------------
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sdvl_side_t        sq_side;

	sdvl_isqrt #(
		.RAD_W (RAD_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// ------------------------------------------------------------------
	// Final stage: fold the window to the direction of motion, compare
	// the near bound with vmax, cap the far bound, or zero both for a rotation.
	// ------------------------------------------------------------------
	logic [VMAX_W-1:0]        vmax;
	logic signed [SPD_W:0]    wlo_x, whi_x, neg_whi, lo, hi;
	logic signed [CMPV_W-1:0] vmax_x, lo_x, hi_x, cap_x;
	logic                     fits, ok;
	speed_t                   nlo, nhi;

	always_comb begin
		vmax    = sq_root[ROOT_W-1:1];
		wlo_x   = {sq_side.wlo[SPD_W-1], sq_side.wlo};
		whi_x   = {sq_side.whi[SPD_W-1], sq_side.whi};
		neg_whi = -whi_x;
		if (sq_side.neg) begin
			lo = neg_whi[SPD_W] ? '0 : neg_whi;
			hi = -wlo_x;
		end else begin
			lo = wlo_x[SPD_W] ? '0 : wlo_x;
			hi = whi_x;
		end
		vmax_x = $signed(CMPV_W'(vmax));
		lo_x   = CMPV_W'(lo);
		hi_x   = CMPV_W'(hi);
		fits   = lo_x < vmax_x;
		cap_x  = (hi_x < vmax_x) ? hi_x : vmax_x;
		ok     = sq_side.pass && (sq_side.rot || fits);
		nlo    = sq_side.wlo;
		nhi    = sq_side.whi;
		if (ok) begin
			if (sq_side.rot) begin
				nlo = '0;
				nhi = '0;
			end else if (sq_side.neg) begin
				nlo = SPD_W'(-cap_x);
			end else begin
				nhi = SPD_W'(cap_x);
			end
		end
	end

	// Output register: the strobe lasts one cycle per transaction.
	logic   done_q;
	logic   admissible_q;
	speed_t new_low_q, new_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		admissible_q <= ok;
		new_low_q    <= nlo;
		new_high_q   <= nhi;
	end

	assign done       = done_q;
	assign admissible = admissible_q;
	assign new_low    = new_low_q;
	assign new_high   = new_high_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SDVL_ASSERT_IMPLY(a_latency, done, $past(accept, LAT), "result without matching transaction")
	`SDVL_ASSERT_NEXT(a_reject, sq_valid && !sq_side.pass, done && !admissible, "threshold miss admitted")
	`SDVL_ASSERT_NEXT(a_rotate, sq_valid && sq_side.rot && sq_side.pass, admissible && new_low == '0 && new_high == '0, "rotation window not cleared")
	`SDVL_ASSERT_IMPLY(a_hold, done && !admissible, new_low == $past(window_low, LAT) && new_high == $past(window_high, LAT), "rejected window altered")

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stopping_distance_velocity_limit_core. A behavioral
// predictor computes the admissibility verdict and the capped speed window
// of every accepted trajectory. A result monitor compares each done pulse
// with the oldest pending verdict. Directed corners run first, then random
// traffic under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

	import sdvl_pkg::*;

	localparam int CLR_W       = 16;
	localparam int PIPE_CYCLES = (CLR_W + 16) / 2 + 4;
	localparam int PRINT_LIMIT = 40;

	// One candidate trajectory as driven on the command ports
	typedef struct {
		logic [CLR_W-1:0]         clearance;
		speed_t                   traj_speed;
		speed_t                   window_low;
		speed_t                   window_high;
		speed_t                   robot_speed;
		logic signed [RATE_W-1:0] turn_rate;
		logic                     emergency;
	} traj_item_t;

	// Verdict and speed window expected on the result ports
	typedef struct {
		logic   admissible;
		speed_t new_low;
		speed_t new_high;
	} window_verdict_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_wdata;
	logic                     start;
	logic                     busy;
	logic [CLR_W-1:0]         clearance;
	speed_t                   traj_speed;
	speed_t                   window_low;
	speed_t                   window_high;
	speed_t                   robot_speed;
	logic signed [RATE_W-1:0] robot_turn_rate;
	logic                     emergency_active;
	logic                     done;
	logic                     admissible;
	speed_t                   new_low;
	speed_t                   new_high;

	// Predictor copy of the register file
	logic [INTV_W-1:0]  cur_interval;
	logic [MINC_W-1:0]  cur_min_clear;
	logic [GUARD_W-1:0] cur_guard;
	logic [ACC_W-1:0]   cur_accel;
	logic [SCALE_W-1:0] cur_scale;

	window_verdict_t pending_verdicts[$];

	int mismatch_count;
	int sent_count;
	int rotation_count;
	int admitted_count;
	int settings_count;

	stopping_distance_velocity_limit_core #(
		.DIST_BITS(CLR_W)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.clearance        (clearance),
		.traj_speed       (traj_speed),
		.window_low       (window_low),
		.window_high      (window_high),
		.robot_speed      (robot_speed),
		.robot_turn_rate  (robot_turn_rate),
		.emergency_active (emergency_active),
		.done             (done),
		.admissible       (admissible),
		.new_low          (new_low),
		.new_high         (new_high)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Distance or angle covered during one control cycle, floored
	function automatic longint unsigned cycle_margin(input longint rate);
		longint unsigned rate_mag;
		rate_mag = (rate < 0) ? longint'(-rate) : longint'(rate);
		return (64'(cur_interval) * rate_mag) / 64'd1000;
	endfunction

	// Floored square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic window_verdict_t predict_window(input traj_item_t it);
		window_verdict_t v;
		longint unsigned reach;
		longint unsigned margin;
		longint          vmax;
		longint          wl;
		longint          wh;
		longint          lo_bound;
		longint          hi_bound;
		longint          cap;
		v.admissible = 1'b0;
		v.new_low    = it.window_low;
		v.new_high   = it.window_high;
		wl = it.window_low;
		wh = it.window_high;
		if (it.traj_speed == 0) begin
			// Pure rotation: clearance turned into an angle, checked against guard
			reach  = (64'(it.clearance) * 64'(cur_scale)) >> 16;
			margin = cycle_margin(longint'(it.turn_rate));
			reach  = (reach > margin) ? reach - margin : 0;
			if (it.emergency)
				reach = reach >> 1;
			if (reach > cur_guard) begin
				v.admissible = 1'b1;
				v.new_low    = '0;
				v.new_high   = '0;
			end
		end else begin
			margin = cycle_margin(longint'(it.robot_speed));
			reach  = (64'(it.clearance) > margin) ? 64'(it.clearance) - margin : 0;
			if (it.emergency)
				reach = reach >> 1;
			if (reach > cur_min_clear) begin
				vmax = longint'(floor_root(64'd2 * reach * 64'(cur_accel)) >> 1);
				// Mirror the window when driving backward
				if (it.traj_speed < 0) begin
					lo_bound = (-wh > 0) ? -wh : 0;
					hi_bound = -wl;
				end else begin
					lo_bound = (wl > 0) ? wl : 0;
					hi_bound = wh;
				end
				if (lo_bound < vmax) begin
					v.admissible = 1'b1;
					cap = (hi_bound < vmax) ? hi_bound : vmax;
					if (it.traj_speed < 0)
						v.new_low = speed_t'(-cap);
					else
						v.new_high = speed_t'(cap);
				end
			end
		end
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic traj_item_t traj(input int clr, input int ts, input int wl,
			input int wh, input int rs, input int rr, input bit em);
		traj_item_t it;
		it.clearance   = CLR_W'(clr);
		it.traj_speed  = SPD_W'(ts);
		it.window_low  = SPD_W'(wl);
		it.window_high = SPD_W'(wh);
		it.robot_speed = SPD_W'(rs);
		it.turn_rate   = RATE_W'(rr);
		it.emergency   = em;
		return it;
	endfunction

	// Mostly well-formed trajectories around the thresholds, some raw noise
	function automatic traj_item_t random_item();
		traj_item_t it;
		int lo_b;
		int hi_b;
		int swap;
		int ts;
		int rs;
		int clr;
		int margin;
		if ($urandom_range(99) < 15) begin
			it.clearance   = CLR_W'($urandom);
			it.traj_speed  = SPD_W'($urandom);
			it.window_low  = SPD_W'($urandom);
			it.window_high = SPD_W'($urandom);
			it.robot_speed = SPD_W'($urandom);
			it.turn_rate   = RATE_W'($urandom);
			it.emergency   = 1'($urandom);
			return it;
		end
		lo_b = int'($urandom_range(8190)) - 4095;
		hi_b = int'($urandom_range(8190)) - 4095;
		if (lo_b > hi_b) begin
			swap = lo_b;
			lo_b = hi_b;
			hi_b = swap;
		end
		// Pick the trajectory speed inside the window; a quarter are rotations
		ts = lo_b + int'($urandom_range(hi_b - lo_b));
		if ($urandom_range(3) == 0)
			ts = 0;
		else if (ts == 0)
			ts = 1;
		rs = ts + int'($urandom_range(400)) - 200;
		if (rs > 4095) rs = 4095;
		if (rs < -4095) rs = -4095;
		margin = (int'(cur_interval) * ((rs < 0) ? -rs : rs)) / 1000;
		case ($urandom_range(3))
			0: clr = int'($urandom_range(65535));
			1: clr = int'(cur_min_clear) + margin + int'($urandom_range(64)) - 32;
			default: clr = int'(cur_min_clear) + margin + int'($urandom_range(6000));
		endcase
		if (clr > 65535) clr = 65535;
		if (clr < 0) clr = 0;
		it = traj(clr, ts, lo_b, hi_b, rs, int'($urandom_range(16382)) - 8191,
			$urandom_range(99) < 20);
		return it;
	endfunction

	task automatic mismatch_report(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Hold start and the fields until the core is free, then log the verdict
	task automatic send_item(input traj_item_t it);
		do begin
			@(negedge clk);
			start            <= 1'b1;
			clearance        <= it.clearance;
			traj_speed       <= it.traj_speed;
			window_low       <= it.window_low;
			window_high      <= it.window_high;
			robot_speed      <= it.robot_speed;
			robot_turn_rate  <= it.turn_rate;
			emergency_active <= it.emergency;
		end while (busy);
		pending_verdicts.push_back(predict_window(it));
		sent_count++;
		if (it.traj_speed == 0)
			rotation_count++;
	endtask

	// Drop start for one cycle and scramble the idle fields
	task automatic idle_cycle();
		@(negedge clk);
		start            <= 1'b0;
		clearance        <= CLR_W'($urandom);
		traj_speed       <= SPD_W'($urandom);
		window_low       <= SPD_W'($urandom);
		window_high      <= SPD_W'($urandom);
		robot_speed      <= SPD_W'($urandom);
		robot_turn_rate  <= RATE_W'($urandom);
		emergency_active <= 1'($urandom);
	endtask

	// Stop issuing and wait until every pending verdict has been matched, or give up after a bounded wait
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_verdicts.size() != 0 && waited < 20 * PIPE_CYCLES) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Write all five registers back to back; the core must be empty
	task automatic write_config(input logic [CFG_DATA_W-1:0] interval,
			input logic [CFG_DATA_W-1:0] min_clear, input logic [CFG_DATA_W-1:0] guard,
			input logic [CFG_DATA_W-1:0] accel, input logic [CFG_DATA_W-1:0] scale);
		logic [CFG_DATA_W-1:0] vals[5];
		cfg_reg_t              idx;
		vals = '{interval, min_clear, guard, accel, scale};
		for (int i = 0; i < 5; i++) begin
			idx = cfg_reg_t'(i);
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[i];
			// Keep the predictor copy masked to each register's width
			case (idx)
				REG_INTERVAL:  cur_interval  = vals[i][INTV_W-1:0];
				REG_MIN_CLEAR: cur_min_clear = vals[i][MINC_W-1:0];
				REG_GUARD:     cur_guard     = vals[i][GUARD_W-1:0];
				REG_ACCEL:     cur_accel     = vals[i][ACC_W-1:0];
				REG_SCALE:     cur_scale     = vals[i][SCALE_W-1:0];
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// ------------------------------------------------------------------------
	// Result monitor: each done pulse pops the oldest pending verdict
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		window_verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				mismatch_report("result with no trajectory outstanding");
			end else begin
				want = pending_verdicts.pop_front();
				if (admissible !== want.admissible)
					mismatch_report($sformatf("admissible %b, want %b",
						admissible, want.admissible));
				if (new_low !== want.new_low)
					mismatch_report($sformatf("new_low %0d, want %0d",
						new_low, want.new_low));
				if (new_high !== want.new_high)
					mismatch_report($sformatf("new_high %0d, want %0d",
						new_high, want.new_high));
				if (admissible === 1'b1)
					admitted_count++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corners under the reset register values
	task automatic test_default_cases();
		// Rotation: plain accept, guard boundary (70 -> 87 rejects, 71 -> 89 passes)
		send_item(traj(2000, 0, -300, 800, 0, 0, 1'b0));
		send_item(traj(70, 0, -300, 800, 0, 0, 1'b0));
		send_item(traj(71, 0, -300, 800, 0, 0, 1'b0));
		send_item(traj(0, 0, 100, 200, 5, 8191, 1'b0));
		// Rotation margin eats the angle, with and without emergency halving
		send_item(traj(1700, 0, -50, 50, 0, -8192, 1'b0));
		send_item(traj(1700, 0, -50, 50, 0, -8192, 1'b1));
		send_item(traj(65535, 0, -4096, 4095, -4096, 8191, 1'b1));
		// Translation forward and backward, cap at vmax = 500
		send_item(traj(1000, 400, -100, 900, 0, 0, 1'b0));
		send_item(traj(1000, -400, -900, 100, 0, 0, 1'b0));
		// Minimum clearance boundary
		send_item(traj(100, 50, 0, 300, 0, 0, 1'b0));
		send_item(traj(101, 50, 0, 300, 0, 0, 1'b0));
		// Lower bound already past vmax: reject
		send_item(traj(1000, 800, 600, 900, 0, 0, 1'b0));
		// Extreme speeds, including the most negative codes
		send_item(traj(65535, 4095, 4095, 4095, 4095, -8191, 1'b0));
		send_item(traj(65535, -4096, -4096, -4096, -4096, 0, 1'b0));
		send_item(traj(65535, -1, -4095, 4095, 0, 0, 1'b1));
		// Inverted window taken as given
		send_item(traj(5000, 200, 800, -800, 100, 0, 1'b0));
		send_item(traj(5000, -200, 800, -800, -100, 0, 1'b0));
		// Robot speed margin clamps the distance to zero
		send_item(traj(500, 100, 0, 300, 4095, 0, 1'b0));
		drain_results();
	endtask

	// Registers near their top values (interval 1000, guard 6283), then with every bit set (masked)
	task automatic test_register_extremes();
		write_config(20'd1000, 20'd65535, 20'd6283, 20'd16383, 20'd1048575);
		send_item(traj(65535, 0, 0, 0, 0, 8191, 1'b0));
		send_item(traj(65535, 3000, -4095, 4095, 10, 0, 1'b0));
		send_item(traj(10000, 0, 0, 0, 0, -8192, 1'b1));
		drain_results();
		write_config('1, '1, '1, '1, '1);
		send_item(traj(65535, 0, 1, 2, 0, 100, 1'b0));
		send_item(traj(65535, -3000, -4095, 4095, 0, 0, 1'b0));
		send_item(traj(65535, 2, -4095, 4095, -4096, 0, 1'b0));
		drain_results();
	endtask

	// All registers zero: braking impossible, so translation always rejects
	task automatic test_zero_braking();
		write_config('0, '0, '0, '0, '0);
		send_item(traj(65535, 1000, -4095, 4095, 4095, 0, 1'b0));
		send_item(traj(1, -1, -10, 10, 0, 0, 1'b1));
		send_item(traj(65535, 0, 5, 6, 0, 8191, 1'b0));
		drain_results();
	endtask

	// Random trajectories under several settings and sender idle rates
	task automatic test_random_traffic();
		int idle_pct[4] = '{0, 70, 0, 10};
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 2)
				write_config(20'd250, 20'd100, 20'd87, 20'd500, 20'd82348);
			else
				write_config(CFG_DATA_W'($urandom_range(1000)),
					CFG_DATA_W'($urandom_range(2000)),
					CFG_DATA_W'($urandom_range(6283)),
					CFG_DATA_W'($urandom_range(1, 16383)),
					CFG_DATA_W'($urandom_range(1048575)));
			for (int k = 0; k < 112; k++) begin
				while ($urandom_range(99) < idle_pct[phase])
					idle_cycle();
				send_item(random_item());
			end
			drain_results();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_INTERVAL;
		cfg_wdata        = '0;
		start            = 1'b0;
		clearance        = '0;
		traj_speed       = '0;
		window_low       = '0;
		window_high      = '0;
		robot_speed      = '0;
		robot_turn_rate  = '0;
		emergency_active = 1'b0;
		// Register defaults after reset
		cur_interval  = 10'd250;
		cur_min_clear = 16'd100;
		cur_guard     = 13'd87;
		cur_accel     = 14'd500;
		cur_scale     = 20'd82348;
		mismatch_count = 0;
		sent_count     = 0;
		rotation_count = 0;
		admitted_count = 0;
		settings_count = 1;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_default_cases();
		test_register_extremes();
		test_zero_braking();
		test_random_traffic();

		// Let the pipeline flush past its latency before closing out
		repeat (PIPE_CYCLES + 5) @(posedge clk);
		if (pending_verdicts.size() != 0)
			mismatch_report($sformatf("%0d trajectories never produced a result",
				pending_verdicts.size()));

		$display("Covered %0d trajectories (%0d pure rotations, %0d admitted) over %0d settings",
			sent_count, rotation_count, admitted_count, settings_count);
		$display("Field mismatches and stray or missing results: %0d", mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
